// ===== hdl/sbf_pkg.sv =====
package sbf_pkg;

    localparam int unsigned CoordW  = 32;
    localparam int unsigned OffW    = 33;
    localparam int unsigned SqW     = 66;
    localparam int unsigned SumW    = 68;
    localparam int unsigned LenW    = 34;
    localparam int unsigned RemW    = 36;
    localparam int unsigned SqSteps = 34;
    localparam int unsigned MagW    = 49;
    localparam int unsigned NumW    = 82;
    localparam int unsigned QuoW    = 32;
    localparam int unsigned DivSteps = 32;

    localparam logic [2:0] CFG_MODE        = 3'd0;
    localparam logic [2:0] CFG_SPRING      = 3'd1;
    localparam logic [2:0] CFG_REST        = 3'd2;
    localparam logic [2:0] CFG_ANCHOR_X    = 3'd3;
    localparam logic [2:0] CFG_ANCHOR_Y    = 3'd4;
    localparam logic [2:0] CFG_ANCHOR_Z    = 3'd5;

    typedef struct packed {
        logic [1:0]                    mode;
        logic [CoordW-1:0]             spring;
        logic [CoordW-1:0]             rest;
        logic [2:0][CoordW-1:0]        anchor;
    } cfg_t;

    typedef struct packed {
        logic [2:0]                    dneg;
        logic [2:0]                    dnz;
        logic [2:0][OffW-1:0]          ad;
    } sq_side_t;

    typedef struct packed {
        logic                          off;
        logic [2:0]                    fneg;
        logic [2:0]                    ovf;
    } res_side_t;

endpackage

// ===== hdl/spring_bungee_force.sv =====
// Hooke spring and bungee force unit, signed Q16.16 throughout.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); write it only
// while no item is in flight. Index 0 mode, 1 spring constant, 2 rest length,
// 3 to 5 anchor x, y and z. Unknown indexes are ignored.
// Input items (pos, other) enter on in_valid/in_stall; each item yields exactly one
// result item (force_x/y/z, applied, clipped) on out_valid/out_stall.
// The pipeline has 76 register stages: 4 for offset, magnitude, squares and sum,
// 34 for the square root (one result bit per stage), 5 for extension, stiffness
// product and the per-axis numerators, 32 for the division by the length (one
// quotient bit per stage) and one output register. One item is taken every cycle
// while the pipeline is not frozen by a held result.
// When out_stall holds a valid result, the whole pipeline freezes and in_stall
// rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and restores the configuration defaults.
module spring_bungee_force (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [31:0]  other_x,
    input  logic signed [31:0]  other_y,
    input  logic signed [31:0]  other_z,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  force_x,
    output logic signed [31:0]  force_y,
    output logic signed [31:0]  force_z,
    output logic                applied,
    output logic                clipped
);
    import sbf_pkg::*;

    cfg_t                    cfg_reg;
    logic                    en;
    logic [2:0][CoordW-1:0]  pos_v, other_v;

    logic                    f_valid, s_valid, c_valid, d_valid;
    logic [SumW-1:0]         f_sum;
    sq_side_t                f_side, s_side;
    logic [LenW-1:0]         s_len, c_len;
    res_side_t               c_side, d_side;
    logic [2:0][LenW-1:0]    c_rem0;
    logic [2:0][QuoW-1:0]    c_lo, d_quo;

    logic                    out_valid_reg;
    logic [2:0][CoordW-1:0]  force_reg, force_next;
    logic                    applied_reg, clipped_reg, applied_next, clipped_next;
    logic [2:0]              clip;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;
    assign pos_v    = {pos_z, pos_y, pos_x};
    assign other_v  = {other_z, other_y, other_x};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode   <= 2'd0;
            cfg_reg.spring <= 32'h0001_0000;
            cfg_reg.rest   <= '0;
            cfg_reg.anchor <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:     cfg_reg.mode      <= cfg_wdata[1:0];
                CFG_SPRING:   cfg_reg.spring    <= cfg_wdata;
                CFG_REST:     cfg_reg.rest      <= cfg_wdata;
                CFG_ANCHOR_X: cfg_reg.anchor[0] <= cfg_wdata;
                CFG_ANCHOR_Y: cfg_reg.anchor[1] <= cfg_wdata;
                CFG_ANCHOR_Z: cfg_reg.anchor[2] <= cfg_wdata;
                default:      cfg_reg           <= cfg_reg;
            endcase
        end
    end

    sbf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .pos      (pos_v),
        .other    (other_v),
        .out_valid(f_valid),
        .sum      (f_sum),
        .out_side (f_side)
    );

    sbf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (f_valid),
        .rad      (f_sum),
        .in_side  (f_side),
        .out_valid(s_valid),
        .len      (s_len),
        .out_side (s_side)
    );

    sbf_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .cfg      (cfg_reg),
        .in_valid (s_valid),
        .len      (s_len),
        .in_side  (s_side),
        .out_valid(c_valid),
        .out_len  (c_len),
        .out_side (c_side),
        .rem0     (c_rem0),
        .num_lo   (c_lo)
    );

    sbf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (c_valid),
        .len      (c_len),
        .in_side  (c_side),
        .rem0     (c_rem0),
        .num_lo   (c_lo),
        .out_valid(d_valid),
        .out_side (d_side),
        .quo      (d_quo)
    );

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            clip[k]       = 1'b0;
            force_next[k] = '0;
            if (d_side.fneg[k])
            begin
                if (d_side.ovf[k] || (d_quo[k] > 32'h8000_0000))
                begin
                    clip[k]       = 1'b1;
                    force_next[k] = 32'h8000_0000;
                end
                else
                begin
                    force_next[k] = 32'd0 - d_quo[k];
                end
            end
            else
            begin
                if (d_side.ovf[k] || d_quo[k][QuoW-1])
                begin
                    clip[k]       = 1'b1;
                    force_next[k] = 32'h7FFF_FFFF;
                end
                else
                begin
                    force_next[k] = d_quo[k];
                end
            end
            if (d_side.off)
            begin
                force_next[k] = '0;
            end
        end
        applied_next = !d_side.off;
        clipped_next = !d_side.off && (clip != 3'b000);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            force_reg   <= force_next;
            applied_reg <= applied_next;
            clipped_reg <= clipped_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign force_x   = force_reg[0];
    assign force_y   = force_reg[1];
    assign force_z   = force_reg[2];
    assign applied   = applied_reg;
    assign clipped   = clipped_reg;

endmodule

// ===== hdl/sbf_front.sv =====
module sbf_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  sbf_pkg::cfg_t                      cfg,
    input  logic                               in_valid,
    input  logic [2:0][sbf_pkg::CoordW-1:0]    pos,
    input  logic [2:0][sbf_pkg::CoordW-1:0]    other,
    output logic                               out_valid,
    output logic [sbf_pkg::SumW-1:0]           sum,
    output sbf_pkg::sq_side_t                  out_side
);
    import sbf_pkg::*;

    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    logic [2:0][OffW-1:0]  d_reg, d_next;
    sq_side_t              s2_reg, s2_next, s3_reg, s4_reg;
    logic [2:0][SqW-1:0]   sq_reg, sq_next;
    logic [SumW-1:0]       sum_reg, sum_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (cfg.mode[0])
            begin
                d_next[k] = {pos[k][CoordW-1], pos[k]}
                          - {cfg.anchor[k][CoordW-1], cfg.anchor[k]};
            end
            else
            begin
                d_next[k] = {pos[k][CoordW-1], pos[k]} - {other[k][CoordW-1], other[k]};
            end
            s2_next.dneg[k] = d_reg[k][OffW-1];
            s2_next.dnz[k]  = (d_reg[k] != '0);
            s2_next.ad[k]   = d_reg[k][OffW-1] ? (OffW'(0) - d_reg[k]) : d_reg[k];
            sq_next[k]      = SqW'(s2_reg.ad[k]) * SqW'(s2_reg.ad[k]);
        end
        sum_next = SumW'(sq_reg[0]) + SumW'(sq_reg[1]) + SumW'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg   <= d_next;
            s2_reg  <= s2_next;
            s3_reg  <= s2_reg;
            sq_reg  <= sq_next;
            s4_reg  <= s3_reg;
            sum_reg <= sum_next;
        end
    end

    assign out_valid = v4_reg;
    assign sum       = sum_reg;
    assign out_side  = s4_reg;

endmodule

// ===== hdl/sbf_sqrt.sv =====
module sbf_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [sbf_pkg::SumW-1:0]    rad,
    input  sbf_pkg::sq_side_t           in_side,
    output logic                        out_valid,
    output logic [sbf_pkg::LenW-1:0]    len,
    output sbf_pkg::sq_side_t           out_side
);
    import sbf_pkg::*;

    logic              v_reg    [SqSteps];
    logic [RemW-1:0]   rem_reg  [SqSteps];
    logic [LenW-1:0]   root_reg [SqSteps];
    logic [SumW-1:0]   rad_reg  [SqSteps];
    sq_side_t          side_reg [SqSteps];

    for (genvar j = 0; j < SqSteps; j++)
    begin : g_step
        logic            pv;
        logic [RemW-1:0] prem, remsh, trial, rem_next;
        logic [LenW-1:0] proot, root_next;
        logic [SumW-1:0] prad;
        sq_side_t        pside;

        if (j == 0)
        begin : g_first
            assign pv    = in_valid;
            assign prem  = '0;
            assign proot = '0;
            assign prad  = rad;
            assign pside = in_side;
        end
        else
        begin : g_rest
            assign pv    = v_reg[j-1];
            assign prem  = rem_reg[j-1];
            assign proot = root_reg[j-1];
            assign prad  = rad_reg[j-1];
            assign pside = side_reg[j-1];
        end

        always_comb
        begin
            remsh = {prem[RemW-3:0], prad[2*(SqSteps-1-j)+1 -: 2]};
            trial = {proot, 2'b01};
            if (remsh >= trial)
            begin
                rem_next  = remsh - trial;
                root_next = {proot[LenW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = remsh;
                root_next = {proot[LenW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                rad_reg[j]  <= prad;
                side_reg[j] <= pside;
            end
        end
    end

    assign out_valid = v_reg[SqSteps-1];
    assign len       = root_reg[SqSteps-1];
    assign out_side  = side_reg[SqSteps-1];

endmodule

// ===== hdl/sbf_scale.sv =====
module sbf_scale (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  sbf_pkg::cfg_t                       cfg,
    input  logic                                in_valid,
    input  logic [sbf_pkg::LenW-1:0]            len,
    input  sbf_pkg::sq_side_t                   in_side,
    output logic                                out_valid,
    output logic [sbf_pkg::LenW-1:0]            out_len,
    output sbf_pkg::res_side_t                  out_side,
    output logic [2:0][sbf_pkg::LenW-1:0]       rem0,
    output logic [2:0][sbf_pkg::QuoW-1:0]       num_lo
);
    import sbf_pkg::*;

    logic                  va_reg, vb_reg, vc_reg, vd_reg, ve_reg;
    logic [LenW-1:0]       len_a_reg, len_b_reg, len_c_reg, len_d_reg, len_e_reg;
    logic [LenW-1:0]       abse_a_reg;
    logic                  off_a_reg, off_b_reg, off_c_reg, off_d_reg;
    logic [2:0]            fneg_a_reg, fneg_b_reg, fneg_c_reg, fneg_d_reg;
    logic [2:0][OffW-1:0]  ad_a_reg, ad_b_reg;
    logic [MagW-1:0]       mag_b_reg;
    logic [2:0][57:0]      pl_c_reg;
    logic [2:0][56:0]      ph_c_reg;
    logic [2:0][NumW-1:0]  num_d_reg;
    res_side_t             side_e_reg;
    logic [2:0][LenW-1:0]  rem_e_reg;
    logic [2:0][QuoW-1:0]  lo_e_reg;

    logic                  lt;
    logic [LenW-1:0]       rest_w, abse_next;
    logic                  off_next;
    logic [2:0]            fneg_next;
    logic [SqW-1:0]        prod;
    logic [2:0][57:0]      pl_next;
    logic [2:0][56:0]      ph_next;
    logic [2:0][NumW-1:0]  num_next;
    res_side_t             side_next;

    always_comb
    begin
        rest_w    = LenW'(cfg.rest);
        lt        = len < rest_w;
        off_next  = (len == '0) || (cfg.mode[1] && lt);
        abse_next = lt ? (rest_w - len) : (len - rest_w);
        for (int k = 0; k < 3; k++)
        begin
            fneg_next[k] = in_side.dnz[k] && (lt == in_side.dneg[k]);
        end
        prod = SqW'(cfg.spring) * SqW'(abse_a_reg);
        for (int k = 0; k < 3; k++)
        begin
            pl_next[k]  = 58'(mag_b_reg[24:0]) * 58'(ad_b_reg[k]);
            ph_next[k]  = 57'(mag_b_reg[MagW-1:25]) * 57'(ad_b_reg[k]);
            num_next[k] = {ph_c_reg[k], 25'b0} + NumW'(pl_c_reg[k]);
        end
        side_next.off  = off_d_reg;
        side_next.fneg = fneg_d_reg;
        for (int k = 0; k < 3; k++)
        begin
            side_next.ovf[k] = num_d_reg[k][NumW-1:QuoW] >= (NumW-QuoW)'(len_d_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_a_reg  <= len;
            abse_a_reg <= abse_next;
            off_a_reg  <= off_next;
            fneg_a_reg <= fneg_next;
            ad_a_reg   <= in_side.ad;

            len_b_reg  <= len_a_reg;
            mag_b_reg  <= prod[MagW+15:16];
            off_b_reg  <= off_a_reg;
            fneg_b_reg <= fneg_a_reg;
            ad_b_reg   <= ad_a_reg;

            len_c_reg  <= len_b_reg;
            pl_c_reg   <= pl_next;
            ph_c_reg   <= ph_next;
            off_c_reg  <= off_b_reg;
            fneg_c_reg <= fneg_b_reg;

            len_d_reg  <= len_c_reg;
            num_d_reg  <= num_next;
            off_d_reg  <= off_c_reg;
            fneg_d_reg <= fneg_c_reg;

            len_e_reg  <= len_d_reg;
            side_e_reg <= side_next;
            for (int k = 0; k < 3; k++)
            begin
                rem_e_reg[k] <= num_d_reg[k][QuoW+LenW-1:QuoW];
                lo_e_reg[k]  <= num_d_reg[k][QuoW-1:0];
            end
        end
    end

    assign out_valid = ve_reg;
    assign out_len   = len_e_reg;
    assign out_side  = side_e_reg;
    assign rem0      = rem_e_reg;
    assign num_lo    = lo_e_reg;

endmodule

// ===== hdl/sbf_div.sv =====
module sbf_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [sbf_pkg::LenW-1:0]            len,
    input  sbf_pkg::res_side_t                  in_side,
    input  logic [2:0][sbf_pkg::LenW-1:0]       rem0,
    input  logic [2:0][sbf_pkg::QuoW-1:0]       num_lo,
    output logic                                out_valid,
    output sbf_pkg::res_side_t                  out_side,
    output logic [2:0][sbf_pkg::QuoW-1:0]       quo
);
    import sbf_pkg::*;

    logic                  v_reg    [DivSteps];
    logic [LenW-1:0]       len_reg  [DivSteps];
    res_side_t             side_reg [DivSteps];
    logic [2:0][LenW-1:0]  rem_reg  [DivSteps];
    logic [2:0][QuoW-1:0]  lo_reg   [DivSteps];
    logic [2:0][QuoW-1:0]  quo_reg  [DivSteps];

    for (genvar j = 0; j < DivSteps; j++)
    begin : g_step
        logic                  pv;
        logic [LenW-1:0]       plen;
        res_side_t             pside;
        logic [2:0][LenW-1:0]  prem, rem_next;
        logic [2:0][QuoW-1:0]  plo, pquo, quo_next;
        logic [LenW:0]         remsh, diff;

        if (j == 0)
        begin : g_first
            assign pv    = in_valid;
            assign plen  = len;
            assign pside = in_side;
            assign prem  = rem0;
            assign plo   = num_lo;
            assign pquo  = '0;
        end
        else
        begin : g_rest
            assign pv    = v_reg[j-1];
            assign plen  = len_reg[j-1];
            assign pside = side_reg[j-1];
            assign prem  = rem_reg[j-1];
            assign plo   = lo_reg[j-1];
            assign pquo  = quo_reg[j-1];
        end

        always_comb
        begin
            remsh = '0;
            diff  = '0;
            for (int k = 0; k < 3; k++)
            begin
                remsh = {prem[k], plo[k][DivSteps-1-j]};
                diff  = remsh - {1'b0, plen};
                if (remsh >= {1'b0, plen})
                begin
                    rem_next[k] = diff[LenW-1:0];
                    quo_next[k] = {pquo[k][QuoW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k] = remsh[LenW-1:0];
                    quo_next[k] = {pquo[k][QuoW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                len_reg[j]  <= plen;
                side_reg[j] <= pside;
                rem_reg[j]  <= rem_next;
                lo_reg[j]   <= plo;
                quo_reg[j]  <= quo_next;
            end
        end
    end

    assign out_valid = v_reg[DivSteps-1];
    assign out_side  = side_reg[DivSteps-1];
    assign quo       = quo_reg[DivSteps-1];

endmodule

// ===== hdl/sbf_checker.sv =====
module sbf_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_stall,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic signed [31:0]  force_x,
    input  logic signed [31:0]  force_y,
    input  logic signed [31:0]  force_z,
    input  logic                applied,
    input  logic                clipped
);

    // The input side only waits on a held result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    a_no_force: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !applied) |->
            (force_x == 32'sd0 && force_y == 32'sd0 && force_z == 32'sd0 && !clipped))
        else $error("force present on an item without applied force");

    a_clip_applied: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clipped) |-> applied)
        else $error("clipped set on an item without applied force");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(force_x) && $stable(force_y)
            && $stable(force_z) && $stable(applied) && $stable(clipped)))
        else $error("stalled result item changed");

endmodule

bind spring_bungee_force sbf_checker u_sbf_checker (.*);

// ===== verif/spring_bungee_force_tb.sv =====
`timescale 1ns / 1ps

module spring_bungee_force_tb;
    import sbf_pkg::*;

    typedef struct {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] other;
    } pair_t;

    typedef struct {
        logic [2:0][31:0] frc;
        logic             applied;
        logic             clipped;
    } force_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic signed [31:0] pos_x, pos_y, pos_z, other_x, other_y, other_z;
    logic        out_valid;
    logic        out_stall;
    logic signed [31:0] force_x, force_y, force_z;
    logic        applied;
    logic        clipped;

    pair_t  pending_pairs[$];
    force_t expected_forces[$];
    int     send_idle_pct;
    int     recv_stall_pct;
    int     errors;

    logic [1:0]       cur_mode;
    logic [31:0]      cur_k;
    logic [31:0]      cur_rest;
    logic [2:0][31:0] cur_anchor;

    spring_bungee_force uut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void queue_pair(pair_t p);
        pending_pairs.insert(pending_pairs.size(), p);
    endfunction

    function automatic force_t hooke_force(pair_t p);
        force_t           r;
        logic signed [32:0] d [3];
        logic [32:0]      ad [3];
        logic [67:0]      sum;
        logic [69:0]      rem;
        logic [69:0]      trial;
        logic [33:0]      len;
        logic [33:0]      ext;
        logic             e_neg;
        logic [65:0]      prod;
        logic [49:0]      mag;
        logic [127:0]     q;
        logic             neg;
        logic [31:0]      ref_pt;
        r.frc = '0;
        r.applied = 1'b0;
        r.clipped = 1'b0;
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            ref_pt = cur_mode[0] ? cur_anchor[i] : p.other[i];
            d[i] = $signed({p.pos[i][31], p.pos[i]}) - $signed({ref_pt[31], ref_pt});
            ad[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
            sum = sum + {35'd0, ad[i]} * {35'd0, ad[i]};
        end
        rem = '0;
        len = '0;
        for (int i = 33; i >= 0; i--)
        begin
            rem = (rem << 2) | 70'(sum[2*i +: 2]);
            trial = (70'(len) << 2) | 70'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                len = (len << 1) | 34'd1;
            end
            else
            begin
                len = len << 1;
            end
        end
        if (len == 0 || (cur_mode[1] && len < {2'b0, cur_rest}))
            return r;
        e_neg = len < {2'b0, cur_rest};
        ext = e_neg ? {2'b0, cur_rest} - len : len - {2'b0, cur_rest};
        prod = {34'd0, cur_k} * {32'd0, ext};
        mag = prod[65:16];
        for (int i = 0; i < 3; i++)
        begin
            q = ({78'd0, mag} * {95'd0, ad[i]}) / {94'd0, len};
            neg = (d[i] != 0) && (e_neg == d[i][32]);
            if (neg)
            begin
                if (q > 128'h8000_0000)
                begin
                    q = 128'h8000_0000;
                    r.clipped = 1'b1;
                end
                r.frc[i] = -q[31:0];
            end
            else
            begin
                if (q > 128'h7FFF_FFFF)
                begin
                    q = 128'h7FFF_FFFF;
                    r.clipped = 1'b1;
                end
                r.frc[i] = q[31:0];
            end
        end
        r.applied = 1'b1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            pos_x <= '0; pos_y <= '0; pos_z <= '0;
            other_x <= '0; other_y <= '0; other_z <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_forces.insert(expected_forces.size(),
                                       hooke_force('{pos: {pos_z, pos_y, pos_x},
                                                     other: {other_z, other_y, other_x}}));
            if (!in_valid || !in_stall)
            begin
                if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    pair_t p;
                    p = pending_pairs.pop_front();
                    in_valid <= 1'b1;
                    {pos_z, pos_y, pos_x} <= p.pos;
                    {other_z, other_y, other_x} <= p.other;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_forces.size() == 0)
                begin
                    $error("unexpected result item");
                    errors++;
                end
                else
                begin
                    force_t e;
                    e = expected_forces.pop_front();
                    if (force_x !== e.frc[0])
                    begin
                        $error("force_x expected %h got %h", e.frc[0], force_x);
                        errors++;
                    end
                    if (force_y !== e.frc[1])
                    begin
                        $error("force_y expected %h got %h", e.frc[1], force_y);
                        errors++;
                    end
                    if (force_z !== e.frc[2])
                    begin
                        $error("force_z expected %h got %h", e.frc[2], force_z);
                        errors++;
                    end
                    if (applied !== e.applied)
                    begin
                        $error("applied expected %b got %b", e.applied, applied);
                        errors++;
                    end
                    if (clipped !== e.clipped)
                    begin
                        $error("clipped expected %b got %b", e.clipped, clipped);
                        errors++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic load_config(logic [1:0] m, logic [31:0] k, logic [31:0] rl,
                               logic [31:0] ax, logic [31:0] ay, logic [31:0] az);
        logic [31:0] vals [6];
        logic [2:0]  idx [6];
        vals = '{32'(m), k, rl, ax, ay, az};
        idx = '{CFG_MODE, CFG_SPRING, CFG_REST, CFG_ANCHOR_X, CFG_ANCHOR_Y, CFG_ANCHOR_Z};
        for (int i = 0; i < 6; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_mode = m;
        cur_k = k;
        cur_rest = rl;
        cur_anchor = {az, ay, ax};
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($signed($urandom_range(2000000)) - 1000000);
            default: return 32'($signed($urandom_range(40000000)) - 20000000);
        endcase
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        for (int i = 0; i < 3; i++)
        begin
            p.pos[i] = rand_coord();
            case ($urandom_range(3))
                0: p.other[i] = rand_coord();
                1: p.other[i] = p.pos[i];
                default: p.other[i] = p.pos[i] + 32'($signed($urandom_range(1000000)) - 500000);
            endcase
            if ($urandom_range(3) == 0)
                p.pos[i] = cur_anchor[i] + 32'($signed($urandom_range(1000000)) - 500000);
        end
        return p;
    endfunction

    task automatic drain();
        do @(negedge clk);
        while (pending_pairs.size() > 0 || in_valid || expected_forces.size() > 0);
        repeat (100) @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] big, neg_big;
        errors = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        send_idle_pct = 24;
        recv_stall_pct = 87;
        cur_mode = 2'd0;
        cur_k = 32'h0001_0000;
        cur_rest = '0;
        cur_anchor = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        big = 32'h7FFF_FFFF;
        neg_big = 32'h8000_0000;
        queue_pair('{pos: {3{32'h0001_0000}}, other: {3{32'h0001_0000}}});
        queue_pair('{pos: {3{big}}, other: {3{neg_big}}});
        queue_pair('{pos: {3{neg_big}}, other: {3{big}}});
        queue_pair('{pos: {32'd0, 32'h4_0000, 32'h3_0000}, other: '0});
        drain();

        load_config(2'd2, 32'h0001_0000, 32'h0005_0000, '0, '0, '0);
        queue_pair('{pos: {32'd0, 32'h4_0000, 32'h3_0000}, other: '0});
        queue_pair('{pos: {32'd0, 32'd0, 32'h1_0000}, other: '0});
        queue_pair('{pos: {32'd0, 32'h8_0000, 32'h6_0000}, other: '0});
        queue_pair('{pos: '0, other: '0});
        queue_pair('{pos: {3{big}}, other: {3{neg_big}}});
        drain();

        load_config(2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, big, neg_big, 32'h0);
        queue_pair('{pos: {32'h0, neg_big, big},
                     other: {32'($urandom()), 32'($urandom()), 32'($urandom())}});
        queue_pair('{pos: {3{neg_big}}, other: '0});
        queue_pair('{pos: {32'h1, neg_big, big}, other: '0});
        drain();

        load_config(2'd3, 32'd0, 32'd0, neg_big, big, neg_big);
        queue_pair('{pos: {neg_big, big, neg_big}, other: '0});
        queue_pair('{pos: {3{big}}, other: '0});
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            send_idle_pct = (ph < 3) ? 24 : (ph < 6) ? 87 : 0;
            recv_stall_pct = (ph < 3) ? 87 : (ph < 6) ? 24 : 0;
            load_config(2'(ph), (ph == 4) ? 32'hFFFF_FFFF : $urandom_range(32'h0004_0000),
                        (ph == 5) ? 32'hFFFF_FFFF : $urandom_range(32'h0100_0000),
                        rand_coord(), rand_coord(), rand_coord());
            for (int n = 0; n < 100; n++)
                queue_pair(rand_pair());
            drain();
        end

        if (errors == 0)
            $display("spring_bungee_force_tb passed");
        else
            $display("spring_bungee_force_tb failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("spring_bungee_force_tb failed");
        $finish;
    end

endmodule
